>>> sv/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// shared types and constants for the byte-serial lz77 decompressor
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int WINDOW_SIZE = 256;
  localparam int OUT_LANES   = 4;
  localparam int HIST_AW     = $clog2(WINDOW_SIZE);
  localparam int LANE_W      = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
  localparam int CNT_W       = 3;
  localparam int LIT_W       = 7;
  localparam int FIFO_DEPTH  = 2;

  localparam logic [7:0] LIT_TOKEN_MASK = 8'hc0;
  localparam logic [7:0] LIT_LEN_MASK   = 8'h3f;
  localparam logic [7:0] COPY_LEN_BASE  = 8'd195;

  typedef enum logic [1:0] {
    PH_TOKEN    = 2'd0,
    PH_LITERAL  = 2'd1,
    PH_DISTANCE = 2'd2
  } phase_t;

  typedef struct packed {
    logic       is_lit;
    logic [7:0] data;
    logic [7:0] len;
  } cmd_t;

endpackage

>>> sv/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front
// stream parser: splits compressed bytes into literal and copy commands
// ----------------------------------------------------------------------------
module lzd_front
  import lzd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_frame_end,
  input  logic       cmd_full,
  output logic       cmd_push,
  output cmd_t       cmd_wdata
);

  phase_t           phase_r, phase_nxt;
  logic [LIT_W-1:0] lit_left_r, lit_left_nxt;
  logic [7:0]       copy_len_r, copy_len_nxt;
  logic             acc;

  assign in_ready = !cmd_full;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TOKEN;
      lit_left_r <= '0;
      copy_len_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      lit_left_r <= lit_left_nxt;
      copy_len_r <= copy_len_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    lit_left_nxt = lit_left_r;
    copy_len_nxt = copy_len_r;
    cmd_push     = 1'b0;
    cmd_wdata    = '{is_lit: 1'b1, data: in_byte, len: copy_len_r};
    if (acc) begin
      unique case (phase_r)
        PH_LITERAL: begin
          cmd_push     = 1'b1;
          lit_left_nxt = lit_left_r - LIT_W'(1);
          if (lit_left_nxt == '0) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_DISTANCE: begin
          cmd_push         = 1'b1;
          cmd_wdata.is_lit = 1'b0;
          copy_len_nxt     = '0;
          phase_nxt        = PH_TOKEN;
        end
        default: begin
          if ((in_byte & LIT_TOKEN_MASK) == LIT_TOKEN_MASK) begin
            lit_left_nxt = LIT_W'(in_byte & LIT_LEN_MASK) + LIT_W'(1);
            phase_nxt    = PH_LITERAL;
          end else begin
            copy_len_nxt = COPY_LEN_BASE - in_byte;
            phase_nxt    = PH_DISTANCE;
          end
        end
      endcase
      if (in_frame_end) begin
        phase_nxt    = PH_TOKEN;
        lit_left_nxt = '0;
        copy_len_nxt = '0;
      end
    end
  end

endmodule

>>> sv/lzd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lzd_cmd_fifo
// short command queue between parser and copy engine
// ----------------------------------------------------------------------------
module lzd_cmd_fifo
  import lzd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output logic nempty,
  output cmd_t rdata
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full   = (cnt_r == CW'(FIFO_DEPTH));
  assign nempty = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

>>> sv/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back
// copy engine: history window, back-reference replay and lane packing
// ----------------------------------------------------------------------------
module lzd_back
  import lzd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_nempty,
  input  cmd_t             cmd_rdata,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_lane [OUT_LANES],
  output logic [CNT_W-1:0] out_count,
  output logic             out_last
);

  logic [7:0]         hist_mem [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] hist_vld_r;

  logic [HIST_AW-1:0] wp_r, src_r;
  logic [7:0]         left_r;
  logic               rd_pend_r, rd_last_r;
  logic [7:0]         rd_data_r, byp_data_r;
  logic               rd_vld_r, byp_r;
  logic [LANE_W-1:0]  lane_r;
  logic [7:0]         acc_r [OUT_LANES];
  logic               out_valid_r;
  logic [7:0]         out_lane_r [OUT_LANES];
  logic [CNT_W-1:0]   out_count_r;
  logic               out_last_r;

  logic               out_free, need_out, consume, issue, idle;
  logic               lit_go, cpy_go, we, load_out;
  logic [7:0]         rd_byte, wdata;
  logic [7:0]         pack [OUT_LANES];

  assign out_free = !out_valid_r || out_ready;
  assign rd_byte  = byp_r ? byp_data_r : (rd_vld_r ? rd_data_r : 8'd0);
  assign need_out = (lane_r == LANE_W'(OUT_LANES - 1)) || rd_last_r;
  assign consume  = rd_pend_r && (!need_out || out_free);
  assign issue    = (left_r != '0) && (!rd_pend_r || consume);
  assign idle     = (left_r == '0) && !rd_pend_r;
  assign lit_go   = idle && cmd_nempty && cmd_rdata.is_lit && out_free;
  assign cpy_go   = idle && cmd_nempty && !cmd_rdata.is_lit;
  assign cmd_pop  = lit_go || cpy_go;
  assign we       = consume || lit_go;
  assign wdata    = consume ? rd_byte : cmd_rdata.data;
  assign load_out = (consume && need_out) || lit_go;

  always_comb begin
    for (int i = 0; i < OUT_LANES; i++) begin
      if (LANE_W'(i) < lane_r) begin
        pack[i] = acc_r[i];
      end else if (LANE_W'(i) == lane_r) begin
        pack[i] = rd_byte;
      end else begin
        pack[i] = 8'd0;
      end
    end
  end

  // history window with registered read and same-cycle write bypass
  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[wp_r] <= wdata;
    end
    if (issue) begin
      rd_data_r  <= hist_mem[src_r];
      rd_vld_r   <= hist_vld_r[src_r];
      byp_r      <= we && (wp_r == src_r);
      byp_data_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (we) begin
      hist_vld_r[wp_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      src_r       <= '0;
      left_r      <= '0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (we) begin
        wp_r <= wp_r + HIST_AW'(1);
      end
      if (cpy_go) begin
        left_r <= cmd_rdata.len;
        src_r  <= wp_r + HIST_AW'(cmd_rdata.data);
      end else if (issue) begin
        left_r <= left_r - 8'd1;
        src_r  <= src_r + HIST_AW'(1);
      end
      if (issue) begin
        rd_pend_r <= 1'b1;
        rd_last_r <= (left_r == 8'd1);
      end else if (consume) begin
        rd_pend_r <= 1'b0;
      end
      if (consume) begin
        lane_r <= need_out ? '0 : lane_r + LANE_W'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // lane accumulator and output register
  always_ff @(posedge clk) begin
    if (consume && !need_out) begin
      acc_r[lane_r] <= rd_byte;
    end
    if (lit_go) begin
      for (int i = 0; i < OUT_LANES; i++) begin
        out_lane_r[i] <= (i == 0) ? cmd_rdata.data : 8'd0;
      end
      out_count_r <= CNT_W'(1);
      out_last_r  <= 1'b1;
    end else if (consume && need_out) begin
      out_lane_r  <= pack;
      out_count_r <= CNT_W'(lane_r) + CNT_W'(1);
      out_last_r  <= rd_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_lane  = out_lane_r;
  assign out_count = out_count_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/lz77_byte_decompressor_top.sv
// ----------------------------------------------------------------------------
// lz77_byte_decompressor_top
// byte-serial lz77 decompressor with a 256-byte history window
//
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    in_byte, in_frame_end
// out      output     out_valid/out_ready  out_byte_0..3, out_byte_count,
//                                          out_run_last
//
// token and literal bytes are taken one per cycle while the command queue
// has room; a copy holds the copy engine while it takes the command, issues
// the first window read, then replays one byte per cycle unless out is held
// history entries are cleared by per-entry valid bits at reset, no sweep
// a full command queue stalls input; a held result stalls the copy engine
// ----------------------------------------------------------------------------
module lz77_byte_decompressor_top
  import lzd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_frame_end,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte_0,
  output logic [7:0]       out_byte_1,
  output logic [7:0]       out_byte_2,
  output logic [7:0]       out_byte_3,
  output logic [CNT_W-1:0] out_byte_count,
  output logic             out_run_last
);

  logic       cmd_push, cmd_full, cmd_pop, cmd_nempty;
  cmd_t       cmd_wdata, cmd_rdata;
  logic [7:0] lane [OUT_LANES];

  lzd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_frame_end (in_frame_end),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_wdata    (cmd_wdata)
  );

  lzd_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (cmd_push),
    .wdata  (cmd_wdata),
    .full   (cmd_full),
    .pop    (cmd_pop),
    .nempty (cmd_nempty),
    .rdata  (cmd_rdata)
  );

  lzd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_nempty (cmd_nempty),
    .cmd_rdata  (cmd_rdata),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_lane   (lane),
    .out_count  (out_byte_count),
    .out_last   (out_run_last)
  );

  assign out_byte_0 = lane[0];
  assign out_byte_1 = lane[1];
  assign out_byte_2 = lane[2];
  assign out_byte_3 = lane[3];

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream test for the byte-serial lz77 decompressor: directed token, literal
// and copy sequences, then random well-formed frames with noise and cut
// frames; every output beat is checked against a predicted byte stream
// ----------------------------------------------------------------------------
module tb_top
  import lzd_pkg::*;
();

  typedef struct packed {
    logic [OUT_LANES-1:0][7:0] data;
    logic [CNT_W-1:0]          count;
    logic                      last;
  } out_beat_t;

  class lz77_scoreboard;
    phase_t                phase;
    logic [LIT_W-1:0]      lit_left;
    logic [7:0]            copy_len;
    logic [7:0]            window [WINDOW_SIZE];
    logic [HIST_AW-1:0]    wr_pos;
    out_beat_t             beats_due [$];
    int unsigned           errors;

    function new();
      phase    = PH_TOKEN;
      lit_left = '0;
      copy_len = '0;
      wr_pos   = '0;
      errors   = 0;
      foreach (window[i]) window[i] = 8'h00;
    endfunction

    function void note_input(logic [7:0] b, logic fend);
      out_beat_t          cur;
      int unsigned        lane;
      int unsigned        left;
      logic [7:0]         v;
      logic [HIST_AW-1:0] rd_pos;
      cur = '0;
      unique case (phase)
        PH_LITERAL: begin
          cur.data[0] = b;
          cur.count   = CNT_W'(1);
          cur.last    = 1'b1;
          beats_due.push_back(cur);
          window[wr_pos] = b;
          wr_pos++;
          lit_left--;
          if (lit_left == 0) phase = PH_TOKEN;
        end
        PH_DISTANCE: begin
          left = 32'(copy_len);
          lane = 0;
          while (left > 0) begin
            rd_pos = wr_pos + b;
            v = window[rd_pos];
            cur.data[lane] = v;
            window[wr_pos] = v;
            wr_pos++;
            lane++;
            left--;
            cur.count = CNT_W'(lane);
            if (lane == OUT_LANES || left == 0) begin
              cur.last = (left == 0);
              beats_due.push_back(cur);
              cur  = '0;
              lane = 0;
            end
          end
          copy_len = '0;
          phase    = PH_TOKEN;
        end
        default: begin
          if ((b & LIT_TOKEN_MASK) == LIT_TOKEN_MASK) begin
            lit_left = LIT_W'(b & LIT_LEN_MASK) + LIT_W'(1);
            phase    = PH_LITERAL;
          end else begin
            copy_len = COPY_LEN_BASE - b;
            phase    = PH_DISTANCE;
          end
        end
      endcase
      if (fend) begin
        phase    = PH_TOKEN;
        lit_left = '0;
        copy_len = '0;
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, got %h", $time, got);
        return;
      end
      want = beats_due.pop_front();
      for (int i = 0; i < OUT_LANES; i++) begin
        if (got.data[i] !== want.data[i]) begin
          errors++;
          $display("%0t: byte_%0d mismatch: expected %02h, got %02h",
                   $time, i, want.data[i], got.data[i]);
        end
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: byte_count mismatch: expected %0d, got %0d",
                 $time, want.count, got.count);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: run_last mismatch: expected %0b, got %0b",
                 $time, want.last, got.last);
      end
    endfunction

    function int pending();
      return beats_due.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_byte;
  logic             in_frame_end;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_byte_0;
  logic [7:0]       out_byte_1;
  logic [7:0]       out_byte_2;
  logic [7:0]       out_byte_3;
  logic [CNT_W-1:0] out_byte_count;
  logic             out_run_last;

  lz77_scoreboard sb = new();
  int unsigned    bytes_sent;
  int             burst_left;
  bit             hold_req;

  lz77_byte_decompressor_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte_0    (out_byte_0),
    .out_byte_1    (out_byte_1),
    .out_byte_2    (out_byte_2),
    .out_byte_3    (out_byte_3),
    .out_byte_count(out_byte_count),
    .out_run_last  (out_run_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_byte, in_frame_end);
      if (out_valid && out_ready) begin
        sb.check_result({out_byte_3, out_byte_2, out_byte_1, out_byte_0,
                         out_byte_count, out_run_last});
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fe);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // receiver: ready runs with short stalls, one long hold-off on request
  initial begin
    int run;
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (400) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        run = $urandom_range(1, 20);
        repeat (run) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        repeat (stall) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    int run_len;
    int cut_at;
    int copy_len;
    int kind;
    bit cut;
    bit fe_tok;
    bit hold_done;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    in_frame_end = 1'b0;
    hold_req     = 1'b0;
    hold_done    = 1'b0;
    bytes_sent   = 0;
    burst_left   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // copy from cleared history, distance 256
    send_byte(8'hbf, 1'b0);
    send_byte(8'h00, 1'b0);
    // literal run with byte extremes
    send_byte(8'hc3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    // overlapping copy at distance 2
    send_byte(8'hbe, 1'b0);
    send_byte(8'hfe, 1'b0);
    // longest copy
    send_byte(8'h00, 1'b0);
    send_byte(8'hfc, 1'b0);
    // literal run cut by frame end
    send_byte(8'hc2, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    // copy token dropped by frame end
    send_byte(8'hb0, 1'b1);
    // single literal
    send_byte(8'hc0, 1'b0);
    send_byte(8'h80, 1'b0);
    // distance byte with frame end
    send_byte(8'hbd, 1'b0);
    send_byte(8'hff, 1'b1);
    // longest literal run, cut early
    send_byte(8'hff, 1'b0);
    send_byte(8'h3c, 1'b1);

    while (bytes_sent < 270) begin
      if (bytes_sent >= 90 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      cut  = ($urandom_range(0, 9) == 0);
      if (kind < 5) begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
                                              : $urandom_range(1, 8);
        cut_at  = cut ? $urandom_range(0, run_len) : run_len + 1;
        send_byte(LIT_TOKEN_MASK | 8'(run_len - 1), cut_at == 0);
        for (int i = 1; i <= run_len && i <= cut_at; i++) begin
          send_byte(8'($urandom), i == cut_at);
        end
      end else if (kind < 9) begin
        copy_len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 195)
                                               : $urandom_range(4, 20);
        fe_tok   = cut && ($urandom_range(0, 1) == 0);
        send_byte(COPY_LEN_BASE - 8'(copy_len), fe_tok);
        if (!fe_tok) send_byte(8'($urandom), cut);
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 3) != 0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
